// File: design/simpint_pkg.sv
// Package for the Simpson integral block: widths, constants, status codes,
// sequencer steps and the structs passed between modules.
// Depends on nothing; every other design file uses it.
package simpint_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CNT_W      = 24;
    localparam int WSUM_W     = 60;
    localparam int STEN_W     = 40;
    localparam int OUT_W      = 64;
    localparam int BIG_W      = 530;
    localparam int BIG_CNT_W  = $clog2(BIG_W + 1);

    localparam int PEAK_SHIFT     = 80;
    localparam int ERR_SHIFT      = 32;
    localparam int UNIT_SHIFT     = 64;
    localparam int PEAK_DEN       = 6;
    localparam int ERR_SCALE      = 1080;
    localparam int MIN_ERR_POINTS = 7;
    localparam int MIN_POINTS     = 2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EVEN  = 2'd1,
        ST_SHORT = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_alu_op;

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_INT_MUL,
        SQ_INT_DIV,
        SQ_H2,
        SQ_H4,
        SQ_PK_DEN,
        SQ_PK_DIV,
        SQ_D2,
        SQ_D4,
        SQ_D5,
        SQ_E,
        SQ_E2,
        SQ_X,
        SQ_SQRT,
        SQ_M2,
        SQ_M4,
        SQ_Q1,
        SQ_Q2,
        SQ_ERR,
        SQ_DONE
    } t_step;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic                overflow;
        logic [SAMPLE_W-1:0] span_mag;
        logic                span_neg;
        logic [WSUM_W-1:0]   wsum_mag;
        logic                wsum_neg;
        logic [SAMPLE_W-1:0] step_mag;
        logic                step_zero;
        logic [STEN_W-1:0]   stencil;
    } t_snapshot;

    typedef struct packed {
        logic [OUT_W-1:0] integral;
        logic [OUT_W-1:0] error_estimate;
        logic [OUT_W-1:0] peak;
        t_status          status;
    } t_result;

endpackage

// File: design/simpint_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on simpint_pkg for the field widths.
interface simpint_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [simpint_pkg::SAMPLE_W-1:0] x_position;
    logic signed [simpint_pkg::SAMPLE_W-1:0] y_sample;
    logic                                 last_sample;

    modport source (output valid, x_position, y_sample, last_sample, input ready);
    modport sink   (input valid, x_position, y_sample, last_sample, output ready);
endinterface

interface simpint_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [simpint_pkg::OUT_W-1:0] integral;
    logic [simpint_pkg::OUT_W-1:0] error_estimate;
    logic [simpint_pkg::OUT_W-1:0] peak_fourth_derivative;
    logic [1:0]                    status;

    modport source (output valid, integral, error_estimate, peak_fourth_derivative,
                    status, input ready);
    modport sink   (input valid, integral, error_estimate, peak_fourth_derivative,
                    status, output ready);
endinterface

// File: design/simpson_integral_with_error.sv
// Top level of the composite Simpson integral block with error estimate.
// Depends on simpint_pkg, simpint_if, simpint_accum and simpint_seq.
//
// Samples (x, y, last flag) arrive on the input channel, one item per cycle
// while the block is collecting a set. Each item updates the weighted sum,
// the sample window and the peak stencil in the cycle it is accepted.
// An item with the last flag set closes the set; ready then drops while a
// sequencer drives one shared bit-serial multiply/divide/root unit.
// Sets of even length, a single point or a count overflow finish without
// using the arithmetic unit. A set under seven points takes one multiply and
// one 530-step divide. A full estimate takes three 530-step divides, a
// 265-step root and fourteen multiplies; a multiply runs until its multiplier
// operand has no set bits left.
// The result item sits in an output register until the receiver takes it;
// a stalled receiver holds the sequencer in its final step, and no sample
// is accepted until the result is handed over to that register.
// Reset clears the set state and the output valid flag; no clearing pass.
module simpson_integral_with_error #(
    parameter int MAX_POINTS = 65535
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    simpint_in_if.sink    i_in,
    simpint_out_if.source o_out
);
    simpint_pkg::t_snapshot snap;
    simpint_pkg::t_result   seq_res;
    simpint_pkg::t_result   r_out;
    logic                   r_out_valid;
    logic                   seq_idle;
    logic                   seq_valid;
    logic                   out_free;
    logic                   accept;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    simpint_accum #(
        .MAX_POINTS (MAX_POINTS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_x      (i_in.x_position),
        .i_y      (i_in.y_sample),
        .i_last   (i_in.last_sample),
        .o_snap   (snap)
    );

    simpint_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && i_in.last_sample),
        .i_snap  (snap),
        .i_ready (out_free),
        .o_idle  (seq_idle),
        .o_valid (seq_valid),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (seq_valid && out_free) begin
            r_out <= seq_res;
        end
    end

    assign i_in.ready                   = seq_idle;
    assign o_out.valid                  = r_out_valid;
    assign o_out.integral               = r_out.integral;
    assign o_out.error_estimate         = r_out.error_estimate;
    assign o_out.peak_fourth_derivative = r_out.peak;
    assign o_out.status                 = r_out.status;

endmodule

// File: design/simpint_alu.sv
// Shared bit-serial wide arithmetic unit: shift-add multiply, restoring
// divide and restoring square root. Depends on simpint_pkg.
module simpint_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  simpint_pkg::t_alu_op          i_op,
    input  logic [simpint_pkg::BIG_W-1:0] i_a,
    input  logic [simpint_pkg::BIG_W-1:0] i_b,
    output logic                          o_done,
    output logic [simpint_pkg::BIG_W-1:0] o_res
);
    localparam int WB = simpint_pkg::BIG_W;
    localparam int CW = simpint_pkg::BIG_CNT_W;

    simpint_pkg::t_alu_op r_op, n_op;
    logic [WB-1:0]  r_a, n_a;
    logic [WB-1:0]  r_b, n_b;
    logic [WB+1:0]  r_p, n_p;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;

    logic [WB+1:0]  lhs;
    logic [WB+1:0]  rhs;
    logic [WB+1:0]  diff;
    logic           ge;

    always_comb begin
        if (r_op == simpint_pkg::OP_SQRT) begin
            lhs = {r_p[WB-1:0], r_b[WB-1:WB-2]};
            rhs = {r_a, 2'b01};
        end else begin
            lhs = {1'b0, r_p[WB-1:0], r_b[WB-1]};
            rhs = {2'b00, r_a};
        end
        ge   = (lhs >= rhs);
        diff = lhs - rhs;
    end

    always_comb begin
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_op   = i_op;
            n_a    = (i_op == simpint_pkg::OP_SQRT) ? '0 : i_a;
            n_b    = i_b;
            n_p    = '0;
            n_cnt  = (i_op == simpint_pkg::OP_DIV) ? CW'(WB) : CW'(WB / 2);
            n_busy = 1'b1;
        end else if (r_busy) begin
            unique case (r_op)
                simpint_pkg::OP_MUL: begin
                    if (r_b == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_p = r_p + (r_b[0] ? {2'b00, r_a} : '0);
                        n_a = {r_a[WB-2:0], 1'b0};
                        n_b = {1'b0, r_b[WB-1:1]};
                    end
                end
                simpint_pkg::OP_DIV: begin
                    if (r_cnt == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_p   = ge ? diff : lhs;
                        n_b   = {r_b[WB-2:0], ge};
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                simpint_pkg::OP_SQRT: begin
                    if (r_cnt == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_p   = ge ? diff : lhs;
                        n_a   = {r_a[WB-2:0], ge};
                        n_b   = {r_b[WB-3:0], 2'b00};
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                default: begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= simpint_pkg::OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
        r_cnt <= n_cnt;
    end

    always_comb begin
        case (r_op)
            simpint_pkg::OP_DIV:  o_res = r_b;
            simpint_pkg::OP_SQRT: o_res = r_a;
            default:              o_res = r_p[WB-1:0];
        endcase
    end

    assign o_done = r_done;

endmodule

// File: design/simpint_accum.sv
// Per-sample accumulation: Simpson weighted sum, six-sample window, peak
// fourth-difference stencil and point count. Depends on simpint_pkg.
module simpint_accum #(
    parameter int MAX_POINTS = 65535
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_accept,
    input  logic signed [simpint_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [simpint_pkg::SAMPLE_W-1:0] i_y,
    input  logic                                    i_last,
    output simpint_pkg::t_snapshot                  o_snap
);
    localparam int SW   = simpint_pkg::SAMPLE_W;
    localparam int CNW  = simpint_pkg::CNT_W;
    localparam int WSW  = simpint_pkg::WSUM_W;
    localparam int STW  = simpint_pkg::STEN_W;
    localparam int SVW  = STW + 2;
    localparam int WIN  = 6;

    localparam logic signed [SVW-1:0] C12 = SVW'(12);
    localparam logic signed [SVW-1:0] C39 = SVW'(39);
    localparam logic signed [SVW-1:0] C56 = SVW'(56);

    logic signed [SW-1:0]  r_win [WIN];
    logic signed [SW-1:0]  r_first, n_first;
    logic signed [SW-1:0]  r_second, n_second;
    logic [CNW-1:0]        r_count, n_count;
    logic signed [WSW-1:0] r_wsum, n_wsum;
    logic [STW-1:0]        r_sten, n_sten;
    logic                  r_ovf, n_ovf;

    logic                  full;
    logic signed [WSW-1:0] y_ext;
    logic signed [WSW-1:0] wy;
    logic signed [SVW-1:0] sv;
    logic [SVW-1:0]        sv_mag;
    logic signed [SW:0]    span;
    logic signed [SW:0]    step;
    logic [SW:0]           span_abs;
    logic [SW:0]           step_abs;

    function automatic logic signed [SVW-1:0] sx(input logic signed [SW-1:0] v);
        return {{(SVW - SW){v[SW-1]}}, v};
    endfunction

    always_comb begin
        full  = r_ovf || (r_count >= CNW'(MAX_POINTS));
        y_ext = {{(WSW - SW){i_y[SW-1]}}, i_y};
        if (i_last || r_count == '0) begin
            wy = y_ext;
        end else if (r_count[0]) begin
            wy = y_ext <<< 2;
        end else begin
            wy = y_ext <<< 1;
        end
        sv = -sx(r_win[0]) + C12 * sx(r_win[1]) - C39 * sx(r_win[2])
             + C56 * sx(r_win[3]) - C39 * sx(r_win[4]) + C12 * sx(r_win[5]) - sx(i_y);
        sv_mag = sv[SVW-1] ? -sv : sv;

        n_first  = r_first;
        n_second = r_second;
        n_count  = r_count;
        n_wsum   = r_wsum;
        n_sten   = r_sten;
        n_ovf    = r_ovf;
        if (full) begin
            n_ovf = 1'b1;
        end else begin
            if (r_count == '0) begin
                n_first = i_x;
            end
            if (r_count == CNW'(1)) begin
                n_second = i_x;
            end
            n_wsum  = r_wsum + wy;
            if (r_count >= CNW'(WIN) && sv_mag[STW-1:0] > r_sten) begin
                n_sten = sv_mag[STW-1:0];
            end
            n_count = r_count + CNW'(1);
        end

        span     = {i_x[SW-1], i_x} - {n_first[SW-1], n_first};
        step     = {n_second[SW-1], n_second} - {n_first[SW-1], n_first};
        span_abs = span[SW] ? -span : span;
        step_abs = step[SW] ? -step : step;

        o_snap.count     = n_count;
        o_snap.overflow  = n_ovf;
        o_snap.span_mag  = span_abs[SW-1:0];
        o_snap.span_neg  = span[SW];
        o_snap.wsum_mag  = n_wsum[WSW-1] ? WSW'(-n_wsum) : WSW'(n_wsum);
        o_snap.wsum_neg  = n_wsum[WSW-1];
        o_snap.step_mag  = step_abs[SW-1:0];
        o_snap.step_zero = (n_second == n_first);
        o_snap.stencil   = n_sten;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wsum  <= '0;
            r_sten  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_count <= '0;
                r_wsum  <= '0;
                r_sten  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_wsum  <= n_wsum;
                r_sten  <= n_sten;
                r_ovf   <= n_ovf;
            end
        end
        if (i_accept) begin
            r_first  <= n_first;
            r_second <= n_second;
            if (!full) begin
                for (int i = 0; i < WIN - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WIN-1] <= i_y;
            end
        end
    end

endmodule

// File: design/simpint_seq.sv
// Sequencer for the end-of-set computation: drives the shared arithmetic
// unit through integral, peak derivative and error steps. Depends on
// simpint_pkg and simpint_alu.
module simpint_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  simpint_pkg::t_snapshot i_snap,
    input  logic                   i_ready,
    output logic                   o_idle,
    output logic                   o_valid,
    output simpint_pkg::t_result   o_res
);
    localparam int WB  = simpint_pkg::BIG_W;
    localparam int OW  = simpint_pkg::OUT_W;
    localparam int CNW = simpint_pkg::CNT_W;

    simpint_pkg::t_step     r_state, n_state;
    logic                   r_wait, n_wait;
    simpint_pkg::t_snapshot r_snap, n_snap;
    simpint_pkg::t_result   r_res, n_res;
    logic [WB-1:0]          r_t0, n_t0;
    logic [WB-1:0]          r_t1, n_t1;
    logic [WB-1:0]          r_t2, n_t2;

    logic                   alu_start;
    simpint_pkg::t_alu_op   alu_op;
    logic [WB-1:0]          alu_a;
    logic [WB-1:0]          alu_b;
    logic                   alu_done;
    logic [WB-1:0]          alu_res;

    logic [CNW-1:0]         m;
    logic [WB-1:0]          m_big;
    logic [WB-1:0]          span_big;
    logic [WB-1:0]          step_big;
    logic [WB-1:0]          sten_big;
    logic [OW-1:0]          im;

    function automatic logic [OW-1:0] sat64(input logic [WB-1:0] v);
        return (|v[WB-1:OW]) ? '1 : v[OW-1:0];
    endfunction

    simpint_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_comb begin
        m        = r_snap.count - CNW'(1);
        m_big    = WB'(m);
        span_big = WB'(r_snap.span_mag);
        step_big = WB'(r_snap.step_mag);
        sten_big = WB'(r_snap.stencil);
        im       = sat64(alu_res);

        n_state = r_state;
        n_wait  = r_wait;
        n_snap  = r_snap;
        n_res   = r_res;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_t2    = r_t2;
        alu_op  = simpint_pkg::OP_MUL;
        alu_a   = '0;
        alu_b   = '0;
        o_idle  = 1'b0;
        o_valid = 1'b0;

        unique case (r_state)
            simpint_pkg::SQ_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_snap = i_snap;
                    n_res  = '0;
                    if (i_snap.overflow || i_snap.count < CNW'(simpint_pkg::MIN_POINTS)) begin
                        n_res.status = simpint_pkg::ST_BAD;
                        n_state      = simpint_pkg::SQ_DONE;
                    end else if (!i_snap.count[0]) begin
                        n_res.status = simpint_pkg::ST_EVEN;
                        n_state      = simpint_pkg::SQ_DONE;
                    end else begin
                        n_state = simpint_pkg::SQ_INT_MUL;
                    end
                end
            end
            simpint_pkg::SQ_INT_MUL: begin
                alu_a = span_big;
                alu_b = WB'(r_snap.wsum_mag);
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_INT_DIV;
                end
            end
            simpint_pkg::SQ_INT_DIV: begin
                alu_op = simpint_pkg::OP_DIV;
                alu_a  = m_big + (m_big << 1);
                alu_b  = r_t0;
                if (alu_done) begin
                    if (r_snap.span_neg != r_snap.wsum_neg) begin
                        n_res.integral = im[OW-1] ? {1'b1, {(OW - 1){1'b0}}} : -im;
                    end else begin
                        n_res.integral = im[OW-1] ? {1'b0, {(OW - 1){1'b1}}} : im;
                    end
                    if (r_snap.count < CNW'(simpint_pkg::MIN_ERR_POINTS)) begin
                        n_res.status = simpint_pkg::ST_SHORT;
                        n_state      = simpint_pkg::SQ_DONE;
                    end else if (r_snap.step_zero) begin
                        n_res.status = simpint_pkg::ST_BAD;
                        n_state      = simpint_pkg::SQ_DONE;
                    end else begin
                        n_state = simpint_pkg::SQ_H2;
                    end
                end
            end
            simpint_pkg::SQ_H2: begin
                alu_a = step_big;
                alu_b = step_big;
                if (alu_done) begin
                    n_t1    = alu_res;
                    n_state = simpint_pkg::SQ_H4;
                end
            end
            simpint_pkg::SQ_H4: begin
                alu_a = r_t1;
                alu_b = r_t1;
                if (alu_done) begin
                    n_t1    = alu_res;
                    n_state = simpint_pkg::SQ_PK_DEN;
                end
            end
            simpint_pkg::SQ_PK_DEN: begin
                alu_a = r_t1;
                alu_b = WB'(simpint_pkg::PEAK_DEN);
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_PK_DIV;
                end
            end
            simpint_pkg::SQ_PK_DIV: begin
                alu_op = simpint_pkg::OP_DIV;
                alu_a  = r_t0;
                alu_b  = sten_big << simpint_pkg::PEAK_SHIFT;
                if (alu_done) begin
                    n_res.peak = im;
                    n_state    = simpint_pkg::SQ_D2;
                end
            end
            simpint_pkg::SQ_D2: begin
                alu_a = span_big;
                alu_b = span_big;
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_D4;
                end
            end
            simpint_pkg::SQ_D4: begin
                alu_a = r_t0;
                alu_b = r_t0;
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_D5;
                end
            end
            simpint_pkg::SQ_D5: begin
                alu_a = r_t0;
                alu_b = span_big;
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_E;
                end
            end
            simpint_pkg::SQ_E: begin
                alu_a = r_t0;
                alu_b = sten_big;
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_E2;
                end
            end
            simpint_pkg::SQ_E2: begin
                alu_a = r_t0;
                alu_b = r_t0;
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_X;
                end
            end
            simpint_pkg::SQ_X: begin
                alu_a = r_t0;
                alu_b = r_t1 + (WB'(1) << simpint_pkg::UNIT_SHIFT);
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_SQRT;
                end
            end
            simpint_pkg::SQ_SQRT: begin
                alu_op = simpint_pkg::OP_SQRT;
                alu_b  = r_t0;
                if (alu_done) begin
                    n_t0    = alu_res;
                    n_state = simpint_pkg::SQ_M2;
                end
            end
            simpint_pkg::SQ_M2: begin
                alu_a = m_big;
                alu_b = m_big;
                if (alu_done) begin
                    n_t2    = alu_res;
                    n_state = simpint_pkg::SQ_M4;
                end
            end
            simpint_pkg::SQ_M4: begin
                alu_a = r_t2;
                alu_b = r_t2;
                if (alu_done) begin
                    n_t2    = alu_res;
                    n_state = simpint_pkg::SQ_Q1;
                end
            end
            simpint_pkg::SQ_Q1: begin
                alu_a = r_t2;
                alu_b = WB'(simpint_pkg::ERR_SCALE);
                if (alu_done) begin
                    n_t2    = alu_res;
                    n_state = simpint_pkg::SQ_Q2;
                end
            end
            simpint_pkg::SQ_Q2: begin
                alu_a = r_t2;
                alu_b = r_t1;
                if (alu_done) begin
                    n_t2    = alu_res;
                    n_state = simpint_pkg::SQ_ERR;
                end
            end
            simpint_pkg::SQ_ERR: begin
                alu_op = simpint_pkg::OP_DIV;
                alu_a  = r_t2 << simpint_pkg::ERR_SHIFT;
                alu_b  = r_t0;
                if (alu_done) begin
                    n_res.error_estimate = im;
                    n_res.status         = simpint_pkg::ST_OK;
                    n_state              = simpint_pkg::SQ_DONE;
                end
            end
            simpint_pkg::SQ_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = simpint_pkg::SQ_IDLE;
                end
            end
            default: begin
                n_state = simpint_pkg::SQ_IDLE;
            end
        endcase

        alu_start = (r_state != simpint_pkg::SQ_IDLE) && (r_state != simpint_pkg::SQ_DONE)
                    && !r_wait;
        if (alu_start) begin
            n_wait = 1'b1;
        end else if (alu_done) begin
            n_wait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= simpint_pkg::SQ_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
        r_snap <= n_snap;
        r_res  <= n_res;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_t2   <= n_t2;
    end

    assign o_res = r_res;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the Simpson integral block with error estimate.
// Depends on simpint_pkg, simpint_if and the simpson_integral_with_error top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_PTS   = 65535;
    localparam int WDOG_LIMIT = 40000;
    localparam int ITEM_GOAL  = 1100;

    typedef struct {
        logic [31:0]          x;
        logic [31:0]          y;
        logic                 last;
        bit                   typed;
        simpint_pkg::t_result res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    simpint_in_if  in_ch();
    simpint_out_if out_ch();

    simpson_integral_with_error #(.MAX_POINTS(MAX_PTS)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state for the set being collected.
    longint          sample_hist[6];
    longint          x_first;
    longint          x_second;
    int unsigned     n_points;
    longint          simpson_sum;
    longint unsigned peak_stencil;
    bit              set_overflow;

    simpint_pkg::t_result pending_results[$];
    int      n_errors = 0;
    int      n_items = 0;
    bit      idle_on = 1'b1;
    int      quiet_cycles = 0;
    int      stall_left = 0;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [63:0] clamp64(logic [639:0] v);
        return (v >> 64) != 0 ? '1 : v[63:0];
    endfunction

    function automatic logic [63:0] root_floor(logic [639:0] v);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        if ((v >> 128) != 0) return '1;
        for (int i = 63; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if (128'(cand) * 128'(cand) <= v[127:0]) r = cand;
        end
        return r;
    endfunction

    function automatic simpint_pkg::t_result close_set(longint x_last);
        simpint_pkg::t_result r;
        longint unsigned m, dmag, im;
        longint dx;
        bit neg;
        logic [639:0] bd, p, q, h, h4, m4, d5, nn, den;
        r = '0;
        r.status = simpint_pkg::ST_OK;
        if (set_overflow || n_points <= 1) begin
            r.status = simpint_pkg::ST_BAD;
        end else if (n_points[0] == 1'b0) begin
            r.status = simpint_pkg::ST_EVEN;
        end else begin
            m = n_points - 1;
            dx = x_last - x_first;
            dmag = magnitude(dx);
            neg = (dx < 0) != (simpson_sum < 0);
            bd = 640'(dmag);
            p = bd * 640'(magnitude(simpson_sum));
            q = p / 640'(3 * m);
            im = clamp64(q);
            if (neg) begin
                r.integral = im >= 64'h8000_0000_0000_0000 ? 64'h8000_0000_0000_0000
                                                           : 64'd0 - im;
            end else begin
                r.integral = im > 64'h7fff_ffff_ffff_ffff ? 64'h7fff_ffff_ffff_ffff : im;
            end
            if (n_points < 7) begin
                r.status = simpint_pkg::ST_SHORT;
            end else if (x_second == x_first) begin
                r.status = simpint_pkg::ST_BAD;
            end else begin
                h = 640'(magnitude(x_second - x_first));
                h4 = h * h * h * h;
                q = (640'(peak_stencil) << 80) / (640'd6 * h4);
                r.peak = clamp64(q);
                d5 = bd * bd * bd * bd * bd;
                nn = d5 * 640'(peak_stencil);
                nn = nn * nn * ((640'd1 << 64) + h4);
                m4 = 640'(m) * 640'(m) * 640'(m) * 640'(m);
                den = (640'd1080 * m4 * h4) << 32;
                den = den * den;
                r.error_estimate = root_floor(nn / den);
            end
        end
        return r;
    endfunction

    task automatic take_sample(input logic [31:0] xr, input logic [31:0] yr, input logic last,
                               output bit done, output simpint_pkg::t_result r);
        longint x, y, sv, w, s;
        int unsigned k;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        if (set_overflow || n_points >= MAX_PTS) begin
            set_overflow = 1'b1;
        end else begin
            k = n_points;
            if (k == 0) x_first = x;
            if (k == 1) x_second = x;
            w = (last || k == 0) ? 1 : (k[0] ? 4 : 2);
            s = simpson_sum + w * y;
            if (w * y > 0 && s < simpson_sum) s = 64'sh7fff_ffff_ffff_ffff;
            if (w * y < 0 && s > simpson_sum) s = 64'sh8000_0000_0000_0000;
            simpson_sum = s;
            if (k >= 6) begin
                sv = -sample_hist[0] + 12 * sample_hist[1] - 39 * sample_hist[2]
                     + 56 * sample_hist[3] - 39 * sample_hist[4] + 12 * sample_hist[5] - y;
                if (magnitude(sv) > peak_stencil) peak_stencil = magnitude(sv);
            end
            for (int i = 0; i < 5; i++) sample_hist[i] = sample_hist[i + 1];
            sample_hist[5] = y;
            n_points = k + 1;
        end
        done = last;
        if (last) begin
            r = close_set(x);
            foreach (sample_hist[i]) sample_hist[i] = 0;
            x_first = 0;
            x_second = 0;
            n_points = 0;
            simpson_sum = 0;
            peak_stencil = 0;
            set_overflow = 1'b0;
        end
    endtask

    task automatic send_sample(input logic [31:0] x, input logic [31:0] y, input logic last,
                               input bit typed, input simpint_pkg::t_result typed_res);
        bit done;
        simpint_pkg::t_result r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.x_position  <= x;
        in_ch.y_sample    <= y;
        in_ch.last_sample <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        n_items++;
        take_sample(x, y, last, done, r);
        if (done) pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        simpint_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", out_ch.integral, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.integral !== want.integral)
                    report_mismatch("integral", out_ch.integral, want.integral);
                if (out_ch.error_estimate !== want.error_estimate)
                    report_mismatch("error_estimate", out_ch.error_estimate,
                                    want.error_estimate);
                if (out_ch.peak_fourth_derivative !== want.peak)
                    report_mismatch("peak_fourth_derivative",
                                    out_ch.peak_fourth_derivative, want.peak);
                if (out_ch.status !== want.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        simpint_pkg::t_result zero_res;
        int len;
        logic [31:0] x, step;

        in_ch.valid = 1'b0;
        in_ch.x_position = '0;
        in_ch.y_sample = '0;
        in_ch.last_sample = 1'b0;
        foreach (sample_hist[i]) sample_hist[i] = 0;
        x_first = 0;
        x_second = 0;
        n_points = 0;
        simpson_sum = 0;
        peak_stencil = 0;
        set_overflow = 1'b0;
        zero_res = '0;

        // Single point, two points, a short set of extremes, a zero-spacing set and
        // a nine-point set of alternating extremes.
        row = '{32'h0, 32'h7fff_ffff, 1'b1, 1'b1, zero_res};
        row.res.status = simpint_pkg::ST_BAD;
        rows.push_back(row);
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, zero_res});
        row = '{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1, zero_res};
        row.res.status = simpint_pkg::ST_EVEN;
        rows.push_back(row);
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, zero_res});
        rows.push_back('{32'h0, 32'h7fff_ffff, 1'b0, 1'b0, zero_res});
        rows.push_back('{32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, zero_res});
        for (int i = 0; i < 7; i++) begin
            row = '{32'h0001_0000, (i[0] ? 32'h7fff_ffff : 32'h8000_0000), i == 6, 1'b0,
                    zero_res};
            if (i == 6) begin
                row.typed = 1'b1;
                row.res.status = simpint_pkg::ST_BAD;
            end
            rows.push_back(row);
        end
        for (int i = 0; i < 9; i++) begin
            rows.push_back('{32'(i * 32'h0001_0000), (i[0] ? 32'h8000_0000 : 32'h7fff_ffff),
                             i == 8, 1'b0, zero_res});
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_sample(rows[i].x, rows[i].y, rows[i].last, rows[i].typed,
                                      rows[i].res);

        while (n_items < ITEM_GOAL) begin
            if (n_items > ITEM_GOAL * 9 / 10) idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, 6);
                1: len = 2 * $urandom_range(1, 10);
                default: len = 2 * $urandom_range(3, 20) + 1;
            endcase
            x = $urandom;
            step = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000);
            for (int i = 0; i < len; i++) begin
                send_sample(($urandom_range(0, 9) == 0) ? $urandom : x,
                            ($urandom_range(0, 3) == 0) ? $urandom
                                                         : 32'($signed($urandom_range(0, 4095))
                                                               - 2048) <<< 8,
                            i == len - 1, 1'b0, zero_res);
                x = x + step;
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: simpson_integral_with_error.f
design/simpint_pkg.sv
design/simpint_if.sv
design/simpint_alu.sv
design/simpint_accum.sv
design/simpint_seq.sv
design/simpson_integral_with_error.sv
test/tb_top.sv
